### src/bgs_pkg.sv
// Shared types and constants for the bead gravity sorter.
`timescale 1ns / 1ps

package bgs_pkg;

  localparam int VALUE_W = 4;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
  } in_t;

  typedef struct packed {
    logic [VALUE_W-1:0] sorted_value;
    logic               last_out;
    logic               overflow;
  } out_t;

  typedef struct packed {
    logic valid;
    logic last;
  } tok_t;

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

endpackage

### src/bgs_cell.sv
// One bead column: holds its bead count and, while it holds a bead, adds one bead to each passing row token.
`timescale 1ns / 1ps

module bgs_cell import bgs_pkg::*; #(
  parameter int COL = 0,
  parameter int CW  = 5,
  parameter int SW  = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               load_en,
  input  logic [VALUE_W-1:0] load_value,
  input  logic               adv,
  input  tok_t               tok_in,
  input  logic [SW-1:0]      sum_in,
  output tok_t               tok_out,
  output logic [SW-1:0]      sum_out
);

  logic [CW-1:0] count;
  logic          has_bead;

  assign has_bead = (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      tok_out <= '0;
    end else begin
      if (load_en && (32'(load_value) > COL)) begin
        count <= count + CW'(1);
      end else if (adv && tok_in.valid && has_bead) begin
        count <= count - CW'(1);
      end
      if (adv) begin
        tok_out <= tok_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_out <= sum_in + SW'(has_bead);
    end
  end

endmodule

### src/bead_gravity_sort.sv
// Top level of the bead gravity sorter: load control, column chain and result register.
//
//   channel  | direction | payload      | transfer when
//   load     | in        | in_t         | load_valid && load_ready
//   result   | out       | out_t        | result_valid && result_ready
//
// Items can be loaded back to back; each raises, in parallel, every column counter below its value.
// After the last item, row tokens enter the column chain, one per cycle while the
// result register does not stall; each token passes through every column cell and
// then the result register before its result leaves.
// load_ready is low from the last item until the final result is transferred.
// A stalled result register halts the whole chain. Reset is synchronous.
`timescale 1ns / 1ps

module bead_gravity_sort import bgs_pkg::*; #(
  parameter int MAX_ITEMS = 16,
  parameter int VALUE_MAX = 15
) (
  input  logic clk,
  input  logic rst,
  input  logic load_valid,
  output logic load_ready,
  input  in_t  load_data,
  output logic result_valid,
  input  logic result_ready,
  output out_t result_data
);

  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int SW = $clog2(VALUE_MAX + 1);

  state_t             state;
  logic [CW-1:0]      item_count;
  logic [CW-1:0]      sent;
  logic               dropped;
  logic               adv;
  logic               load_fire;
  logic               has_room;
  logic               load_en;
  logic [VALUE_W-1:0] value_clamped;
  logic               inject;
  logic               result_fire;

  tok_t          tok   [VALUE_MAX+1];
  logic [SW-1:0] sums  [VALUE_MAX+1];

  assign load_ready    = (state == ST_LOAD);
  assign load_fire     = load_valid && load_ready;
  assign has_room      = (32'(item_count) < MAX_ITEMS);
  assign load_en       = load_fire && has_room;
  assign value_clamped = (32'(load_data.value) > VALUE_MAX) ? VALUE_W'(VALUE_MAX)
                                                            : load_data.value;
  assign adv           = !result_valid || result_ready;
  assign inject        = (state == ST_EMIT) && (sent != item_count);
  assign result_fire   = result_valid && result_ready;

  assign tok[0].valid = inject;
  assign tok[0].last  = ((sent + CW'(1)) == item_count);
  assign sums[0]      = '0;

  for (genvar c = 0; c < VALUE_MAX; c++) begin : g_col
    bgs_cell #(
      .COL (c),
      .CW  (CW),
      .SW  (SW)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .load_en    (load_en),
      .load_value (value_clamped),
      .adv        (adv),
      .tok_in     (tok[c]),
      .sum_in     (sums[c]),
      .tok_out    (tok[c+1]),
      .sum_out    (sums[c+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LOAD;
      item_count   <= '0;
      sent         <= '0;
      dropped      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (load_fire) begin
            if (has_room) begin
              item_count <= item_count + CW'(1);
            end else begin
              dropped <= 1'b1;
            end
            if (load_data.last) begin
              state <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (adv && inject) begin
            sent <= sent + CW'(1);
          end
          if (result_fire && result_data.last_out) begin
            state      <= ST_LOAD;
            item_count <= '0;
            sent       <= '0;
            dropped    <= 1'b0;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
      if (adv) begin
        result_valid <= tok[VALUE_MAX].valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result_data.sorted_value <= VALUE_W'(sums[VALUE_MAX]);
      result_data.last_out     <= tok[VALUE_MAX].last;
      result_data.overflow     <= dropped;
    end
  end

`ifndef SYNTHESIS
  a_no_result_while_loading: assert property (@(posedge clk) disable iff (rst)
    load_ready |-> !result_valid)
    else $error("result shown while loading");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(item_count) <= MAX_ITEMS)
    else $error("item count above capacity");

  a_sent_bound: assert property (@(posedge clk) disable iff (rst)
    sent <= item_count)
    else $error("more row tokens than items");

  a_run_end_clears: assert property (@(posedge clk) disable iff (rst)
    (result_fire && result_data.last_out) |=> (load_ready && item_count == '0 && !dropped))
    else $error("store not cleared after final result");
`endif

endmodule

### bench/tb_bead_gravity_sort.sv
// Self-checking testbench for the bead gravity sorter: sets in, sorted rows out.
`timescale 1ns / 1ps

module tb_bead_gravity_sort;
  import bgs_pkg::*;

  localparam int MAX_ITEMS = 16;
  localparam int VALUE_MAX = 15;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic load_valid = 1'b0;
  logic load_ready;
  in_t  load_data = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  out_t result_data;

  logic [4:0] bead_col [VALUE_MAX];
  logic [4:0] stored_cnt;
  logic       set_dropped;
  out_t       expected_rows [$];
  out_t       want;

  bit tx_idle_on = 1'b1;
  bit rx_stall_on = 1'b1;
  int err_count = 0;
  int items_sent = 0;
  int sets_sent = 0;
  int overflow_sets = 0;
  int rows_checked = 0;

  bead_gravity_sort #(
    .MAX_ITEMS(MAX_ITEMS),
    .VALUE_MAX(VALUE_MAX)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .load_valid(load_valid),
    .load_ready(load_ready),
    .load_data(load_data),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result_data(result_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #1_000_000;
    $display("Timeout waiting for results");
    $display("Test completed with failures");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    if (err_count < 50) begin
      $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, exp_val);
    end
    err_count++;
  endtask

  // Stack the beads of one accepted value; on the last value drop them into rows.
  task automatic drop_beads(input in_t item);
    logic [VALUE_W-1:0] v;
    logic [4:0]         beads;
    out_t               row;
    v = item.value;
    if (v > VALUE_MAX) begin
      v = VALUE_MAX[VALUE_W-1:0];
    end
    if (stored_cnt < MAX_ITEMS) begin
      for (int c = 0; c < VALUE_MAX; c++) begin
        if (c < v) begin
          bead_col[c] = bead_col[c] + 5'd1;
        end
      end
      stored_cnt = stored_cnt + 5'd1;
    end else begin
      set_dropped = 1'b1;
    end
    if (item.last) begin
      for (int r = 0; r < stored_cnt; r++) begin
        beads = '0;
        for (int c = 0; c < VALUE_MAX; c++) begin
          if (bead_col[c] > r) begin
            beads = beads + 5'd1;
          end
        end
        row.sorted_value = beads[VALUE_W-1:0];
        row.last_out = (r + 1 == stored_cnt);
        row.overflow = set_dropped;
        expected_rows.push_back(row);
      end
      sets_sent++;
      if (set_dropped) begin
        overflow_sets++;
      end
      for (int c = 0; c < VALUE_MAX; c++) begin
        bead_col[c] = '0;
      end
      stored_cnt = '0;
      set_dropped = 1'b0;
    end
  endtask

  task automatic send_item(input logic [VALUE_W-1:0] value, input logic last);
    in_t item;
    item.value = value;
    item.last = last;
    @(negedge clk);
    load_data <= item;
    load_valid <= 1'b1;
    @(posedge clk);
    while (!load_ready) @(posedge clk);
    drop_beads(item);
    items_sent++;
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      load_valid <= 1'b0;
      repeat ($urandom_range(1, 18) - 1) @(negedge clk);
    end
  endtask

  task automatic send_set(input int size, input int value_mix);
    logic [VALUE_W-1:0] v;
    for (int i = 0; i < size; i++) begin
      case (value_mix)
        0: v = VALUE_W'($urandom_range(0, 3));
        1: v = VALUE_W'($urandom_range(12, 15));
        default: v = VALUE_W'($urandom_range(0, 15));
      endcase
      send_item(v, i == size - 1);
    end
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    load_valid <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
  endtask

  task automatic test_single_values();
    send_item(4'd15, 1'b1);
    send_item(4'd0, 1'b1);
  endtask

  task automatic test_extreme_values();
    send_item(4'd0, 1'b0);
    send_item(4'd15, 1'b0);
    send_item(4'd1, 1'b0);
    send_item(4'd8, 1'b0);
    send_item(4'd0, 1'b1);
  endtask

  // Fill the store, then offer a last value that has no room left.
  task automatic test_full_store();
    for (int i = 0; i < MAX_ITEMS; i++) begin
      send_item(VALUE_W'($urandom_range(0, 15)), 1'b0);
    end
    send_item(4'd15, 1'b1);
    hold_until_drained();
  endtask

  task automatic test_random_sets();
    int target;
    int size;
    target = items_sent + 75;
    while (items_sent < target) begin
      tx_idle_on = $urandom_range(0, 3) != 0;
      rx_stall_on = $urandom_range(0, 3) != 0;
      case ($urandom_range(0, 9))
        0: size = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 4);
        1: size = MAX_ITEMS;
        default: size = $urandom_range(1, MAX_ITEMS - 1);
      endcase
      send_set(size, $urandom_range(0, 2));
      if ($urandom_range(0, 4) == 0) begin
        hold_until_drained();
      end
    end
  endtask

  task automatic test_back_to_back();
    tx_idle_on = 1'b0;
    rx_stall_on = 1'b0;
    send_set(MAX_ITEMS, 2);
    send_set(3, 2);
    send_set(1, 1);
  endtask

  always begin
    @(negedge clk);
    if (rx_stall_on && $urandom_range(0, 4) == 0) begin
      result_ready <= 1'b0;
      repeat ($urandom_range(1, 18) - 1) @(negedge clk);
    end else begin
      result_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (expected_rows.size() == 0) begin
        report_mismatch("unexpected result, sorted_value", result_data.sorted_value, -1);
      end else begin
        want = expected_rows.pop_front();
        rows_checked++;
        if (result_data.sorted_value !== want.sorted_value) begin
          report_mismatch("sorted_value", result_data.sorted_value, want.sorted_value);
        end
        if (result_data.last_out !== want.last_out) begin
          report_mismatch("last_out", result_data.last_out, want.last_out);
        end
        if (result_data.overflow !== want.overflow) begin
          report_mismatch("overflow", result_data.overflow, want.overflow);
        end
      end
    end
  end

  initial begin
    for (int c = 0; c < VALUE_MAX; c++) begin
      bead_col[c] = '0;
    end
    stored_cnt = '0;
    set_dropped = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    test_single_values();
    test_extreme_values();
    test_full_store();
    test_random_sets();
    test_back_to_back();

    @(negedge clk);
    load_valid <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (VALUE_MAX + 8) @(posedge clk);

    if (expected_rows.size() != 0) begin
      report_mismatch("rows left over", expected_rows.size(), 0);
    end
    $display("Loaded %0d values in %0d sets (%0d with dropped values), checked %0d rows",
             items_sent, sets_sent, overflow_sets, rows_checked);
    $display("Mismatches: %0d", err_count);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
